// File: src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_EQ  = 4'd4,
    OP_NE  = 4'd5,
    OP_GT  = 4'd6,
    OP_LT  = 4'd7,
    OP_GE  = 4'd8,
    OP_LE  = 4'd9
  } op_e;

  // A classified item handed from the front part to the back part.
  typedef struct packed {
    logic        arith;
    logic [3:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    logic        err;
    logic        cmp;
  } task_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        cmp;
    logic        err;
  } result_t;

endpackage

// File: src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Each transaction carries two signed fractions and an operation code and
// yields one result transaction. A front part latches the operands, checks
// the input denominators and resolves comparisons; a back part forms the
// 64-bit cross products, reduces the arithmetic result by the binary GCD,
// then divides numerator and denominator by it with a one-bit-per-cycle
// restoring divider, whose last step stores each quotient. Comparisons and
// items with a zero input denominator skip the GCD and the divisions. The
// front register lets a new item be accepted while the back part is still
// busy with the previous one.
module rational_arithmetic_unit #(
  parameter int unsigned IN_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  operation_i,
  input  logic [31:0] lhs_num_i,
  input  logic [31:0] lhs_den_i,
  input  logic [31:0] rhs_num_i,
  input  logic [31:0] rhs_den_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] res_num_o,
  output logic [63:0] res_den_o,
  output logic        compare_true_o,
  output logic        error_code_o
);

  logic f_valid, b_ready, b_valid;
  rau_pkg::task_t   task_w;
  rau_pkg::result_t res_w;

  rau_front #(.InWidth(IN_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .operation_i, .lhs_num_i, .lhs_den_i, .rhs_num_i, .rhs_den_i,
    .valid_o(f_valid), .ready_i(b_ready), .task_o(task_w)
  );

  rau_back u_back (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(b_ready), .task_i(task_w),
    .valid_o(b_valid), .ready_i(pop), .res_o(res_w)
  );

  assign empty          = !b_valid;
  assign res_num_o      = res_w.num;
  assign res_den_o      = res_w.den;
  assign compare_true_o = res_w.cmp;
  assign error_code_o   = res_w.err;

endmodule

// File: src/rau_front.sv
// Front part: sign-extends the operands, checks the input denominators and settles comparisons.
module rau_front #(
  parameter int unsigned InWidth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [3:0]        operation_i,
  input  logic [31:0]       lhs_num_i,
  input  logic [31:0]       lhs_den_i,
  input  logic [31:0]       rhs_num_i,
  input  logic [31:0]       rhs_den_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rau_pkg::task_t    task_o
);

  logic [1:0] state_q, state_d;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  rau_pkg::task_t t_q, t_d;
  logic [63:0] ad_q, cb_q;

  function automatic logic [63:0] sext(input logic [31:0] v);
    sext = {{(64 - InWidth){v[InWidth-1]}}, v[InWidth-1:0]};
  endfunction

  assign full_o  = (state_q != S_IDLE);
  assign valid_o = (state_q == S_OUT);
  assign task_o  = t_q;

  logic same, gt, lt;
  always_comb begin
    same = (t_q.a == t_q.c) && (t_q.b == t_q.d);
    gt = $signed(ad_q) > $signed(cb_q);
    lt = $signed(ad_q) < $signed(cb_q);
  end

  always_comb begin
    state_d = state_q;
    t_d = t_q;
    unique case (state_q)
      S_IDLE: begin
        if (push_i) begin
          t_d.op  = operation_i;
          t_d.a   = sext(lhs_num_i);
          t_d.b   = sext(lhs_den_i);
          t_d.c   = sext(rhs_num_i);
          t_d.d   = sext(rhs_den_i);
          t_d.err = (t_d.b == '0) || (t_d.d == '0);
          t_d.arith = !t_d.err && (operation_i <= rau_pkg::OP_DIV);
          t_d.cmp = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // Cross products of the raw fields are ready; resolve comparisons.
        case (t_q.op)
          rau_pkg::OP_EQ: t_d.cmp = same;
          rau_pkg::OP_NE: t_d.cmp = !same;
          rau_pkg::OP_GT: t_d.cmp = gt;
          rau_pkg::OP_LT: t_d.cmp = lt;
          rau_pkg::OP_GE: t_d.cmp = same || gt;
          rau_pkg::OP_LE: t_d.cmp = same || lt;
          default:        t_d.cmp = 1'b0;
        endcase
        if (t_q.err) t_d.cmp = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    // The raw cross products are formed from the operands as they are taken in.
    if (state_q == S_IDLE) begin
      ad_q <= 64'($signed(t_d.a[31:0]) * $signed(t_d.d[31:0]));
      cb_q <= 64'($signed(t_d.c[31:0]) * $signed(t_d.b[31:0]));
    end
  end

endmodule

// File: src/rau_back.sv
// Back part: cross products, binary GCD and the two reducing divisions.
module rau_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rau_pkg::task_t    task_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rau_pkg::result_t  res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_M1    = 4'd1;
  localparam logic [3:0] S_M2    = 4'd2;
  localparam logic [3:0] S_M3    = 4'd3;
  localparam logic [3:0] S_M4    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_TWO   = 4'd6;
  localparam logic [3:0] S_XODD  = 4'd7;
  localparam logic [3:0] S_LOOP  = 4'd8;
  localparam logic [3:0] S_DIVN  = 4'd9;
  localparam logic [3:0] S_DIVD  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_q, state_d;
  rau_pkg::task_t t_q;
  logic [63:0] p_q, num_q, den_q, x_q, y_q, g_q;
  logic [5:0]  k_q;
  // Restoring divider.
  logic [63:0] dq_q, dr_q;
  logic [6:0]  dcnt_q;
  rau_pkg::result_t r_q;

  logic [63:0] mul_x, mul_y, prod;
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_q)
      S_M1: begin mul_x = t_q.a; mul_y = (t_q.op == rau_pkg::OP_MUL) ? t_q.c : t_q.d; end
      S_M2: begin mul_x = t_q.c; mul_y = t_q.b; end
      S_M3: begin mul_x = t_q.b; mul_y = (t_q.op == rau_pkg::OP_DIV) ? t_q.c : t_q.d; end
      default: ;
    endcase
  end
  // Operands are sign-extended 32-bit values, so the low 64 bits of the
  // signed 32x32 product equal the wrapped 64-bit product.
  assign prod = 64'($signed(mul_x[31:0]) * $signed(mul_y[31:0]));

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  logic [64:0] trial;
  assign trial = {dr_q, dq_q[63]} - {1'b0, g_q};

  assign ready_o = (state_q == S_IDLE);
  assign valid_o = (state_q == S_OUT);
  assign res_o   = r_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (valid_i) state_d = task_i.arith ? S_M1 : S_OUT;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_CHK;
      S_CHK:  state_d = (den_q == '0) ? S_OUT : S_TWO;
      S_TWO:  if (x_q == '0 || y_q == '0 || ((x_q | y_q) & 64'd1) != '0) state_d = S_XODD;
      S_XODD: if (x_q == '0 || y_q == '0 || x_q[0]) state_d = S_LOOP;
      S_LOOP: if (x_q == '0 || y_q == '0 || (y_q[0] && x_q == y_q)) state_d = S_DIVN;
      S_DIVN: if (dcnt_q == 7'd64) state_d = S_DIVD;
      S_DIVD: if (dcnt_q == 7'd64) state_d = S_OUT;
      S_OUT:  if (ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q) inside
      S_IDLE: begin
        t_q <= task_i;
        r_q.num <= '0;
        r_q.den <= 64'd1;
        r_q.cmp <= task_i.cmp;
        r_q.err <= task_i.err;
      end
      S_M1: p_q <= prod;
      S_M2: begin
        unique case (t_q.op)
          rau_pkg::OP_ADD: num_q <= p_q + prod;
          rau_pkg::OP_SUB: num_q <= p_q - prod;
          default:         num_q <= p_q;
        endcase
      end
      S_M3: den_q <= prod;
      S_M4: begin
        x_q <= mag(num_q);
        y_q <= mag(den_q);
        k_q <= '0;
      end
      S_CHK: if (den_q == '0) r_q.err <= 1'b1;
      S_TWO: begin
        if (!(x_q == '0 || y_q == '0 || ((x_q | y_q) & 64'd1) != '0)) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + 6'd1;
        end
      end
      S_XODD: if (!(x_q == '0 || y_q == '0 || x_q[0])) x_q <= x_q >> 1;
      S_LOOP: begin
        if (x_q == '0) begin
          g_q <= y_q << k_q;
        end else if (y_q == '0) begin
          g_q <= x_q << k_q;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q == y_q) begin
          g_q <= x_q << k_q;
        end else if (x_q > y_q) begin
          x_q <= y_q;
          y_q <= x_q - y_q;
        end else begin
          y_q <= y_q - x_q;
        end
        dq_q <= mag(num_q);
        dr_q <= '0;
        dcnt_q <= '0;
      end
      S_DIVN, S_DIVD: begin
        if (dcnt_q == 7'd64) begin
          if (state_q == S_DIVN) begin
            r_q.num <= num_q[63] ? (64'd0 - dq_q) : dq_q;
            dq_q <= mag(den_q);
          end else begin
            r_q.den <= den_q[63] ? (64'd0 - dq_q) : dq_q;
          end
          dr_q <= '0;
          dcnt_q <= '0;
        end else begin
          if (!trial[64]) begin
            dr_q <= trial[63:0];
            dq_q <= {dq_q[62:0], 1'b1};
          end else begin
            dr_q <= {dr_q[62:0], dq_q[63]};
            dq_q <= {dq_q[62:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 7'd1;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && !ready_i |=> state_q == S_OUT)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && r_q.err |-> r_q.num == '0 && r_q.den == 64'd1)
    else $error("error result not 0/1");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && r_q.cmp |-> !r_q.err)
    else $error("comparison true with error");

endmodule
